FILE: hw/rtl/frs_pkg.sv
`timescale 1ns / 1ps

package frs_pkg;

  // Fixed field widths and limits of the frame interface.
  localparam int REG_COUNT_DEF = 64;
  localparam int PAYLOAD_MAX   = 32;
  localparam int RESULT_LIMIT  = 32;

  // Command codes carried in the low seven bits of the control byte.
  localparam logic [6:0] OP_PING  = 7'h01;
  localparam logic [6:0] OP_PONG  = 7'h02;
  localparam logic [6:0] OP_WRITE = 7'h03;
  localparam logic [6:0] OP_READ  = 7'h04;
  localparam logic [6:0] OP_ACK   = 7'h05;

  // Bit of the control byte that asks for a write acknowledge.
  localparam int ACK_FLAG_BIT = 7;

  typedef struct packed {
    logic [7:0] frame_source;
    logic [7:0] frame_control;
    logic [5:0] frame_len;
    logic [4:0] byte_pos;
    logic [7:0] byte_value;
    logic       last_byte;
  } frs_req_t;

  typedef struct packed {
    logic [7:0] reply_dest;
    logic [6:0] reply_cmd;
    logic [5:0] reply_len;
    logic [7:0] reply_byte;
    logic       has_byte;
    logic       reply_last;
  } frs_rsp_t;

  // Kind of reply frame pending after the last item of a request.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_READ   = 2'd2
  } frs_kind_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;   // request transaction accepted this cycle
    logic fetch;  // read the register store for the current reply byte
    logic load;   // load the next reply item into the output register
  } frs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    frs_kind_t kind;
    logic      out_free;
    logic      item_last;
    logic      next_mem;
  } frs_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_FETCH  = 4'b0100,
    ST_SEND   = 4'b1000
  } frs_state_t;

endpackage

FILE: hw/rtl/frs_ctrl.sv
`timescale 1ns / 1ps

module frs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  frs_pkg::frs_stat_t stat,
  output frs_pkg::frs_cmd_t  cmd
);
  import frs_pkg::*;

  frs_state_t state;
  frs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.kind == KIND_NONE) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SEND;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          if (stat.item_last) begin
            state_next = ST_IDLE;
          end else if (stat.next_mem) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_SEND;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/frs_datapath.sv
`timescale 1ns / 1ps

module frs_datapath #(
  parameter int REG_COUNT = frs_pkg::REG_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  frs_pkg::frs_req_t  req,
  input  frs_pkg::frs_cmd_t  cmd,
  output frs_pkg::frs_stat_t stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output frs_pkg::frs_rsp_t  rsp
);
  import frs_pkg::*;

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [9:0] REG_LIMIT = 10'(REG_COUNT);

  // Frame header state.
  logic [7:0] latched_start;
  logic [7:0] latched_count;
  logic       frame_ok;

  // Pending reply.
  frs_kind_t  kind;
  logic [7:0] dest;
  logic [6:0] rcmd;
  logic [5:0] rlen;
  logic [5:0] k;

  // Register store with a written bit per entry; an unwritten entry reads as zero.
  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] written;
  logic [7:0]           rdata;
  logic                 rd_ok;

  logic [6:0] cmd_code;
  logic       len_ok;
  logic       byte_hit;
  logic [4:0] pos_off;
  logic [9:0] sum_hdr;
  logic [8:0] widx;
  logic       we;
  logic [7:0] start_next;
  logic [7:0] count_next;
  logic       ok_next;
  logic [8:0] n_reply;
  frs_kind_t  kind_next;
  logic [6:0] rcmd_next;
  logic [5:0] rlen_next;
  logic [8:0] raddr;
  logic [7:0] send_byte;

  assign cmd_code = req.frame_control[6:0];
  assign len_ok   = ({1'b0, req.frame_len} <= 7'(PAYLOAD_MAX));
  assign byte_hit = len_ok && (req.frame_len != 6'd0) && ({1'b0, req.byte_pos} < req.frame_len);
  assign pos_off  = req.byte_pos - 5'd2;
  assign sum_hdr  = {2'b00, latched_start} + {2'b00, req.byte_value};
  assign widx     = {1'b0, latched_start} + {4'b0000, pos_off};

  always_comb begin
    start_next = latched_start;
    count_next = latched_count;
    ok_next    = frame_ok;
    we         = 1'b0;
    if (byte_hit) begin
      if (req.byte_pos == 5'd0) begin
        start_next = req.byte_value;
        ok_next    = 1'b0;
      end else if (req.byte_pos == 5'd1) begin
        count_next = req.byte_value;
        ok_next    = (sum_hdr <= REG_LIMIT);
      end else if (cmd_code == OP_WRITE && frame_ok &&
                   ({3'b000, pos_off} < latched_count) && ({1'b0, widx} < REG_LIMIT)) begin
        we = 1'b1;
      end
    end
  end

  // Reply decision on the last item of a frame, from the header state after this item.
  assign n_reply = {1'b0, count_next} + 9'd2;

  always_comb begin
    kind_next = KIND_NONE;
    rcmd_next = rcmd;
    rlen_next = '0;
    if (len_ok && req.last_byte) begin
      case (cmd_code)
        OP_PING: begin
          kind_next = KIND_SINGLE;
          rcmd_next = OP_PONG;
        end
        OP_WRITE: begin
          if (req.frame_len >= 6'd2 && ok_next && req.frame_control[ACK_FLAG_BIT]) begin
            kind_next = KIND_SINGLE;
            rcmd_next = OP_ACK;
          end
        end
        OP_READ: begin
          if (req.frame_len == 6'd2 && ok_next && n_reply <= 9'(PAYLOAD_MAX) &&
              n_reply <= 9'(RESULT_LIMIT)) begin
            kind_next = KIND_READ;
            rcmd_next = OP_READ;
            rlen_next = n_reply[5:0];
          end
        end
        default: begin
          kind_next = KIND_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_start <= '0;
      latched_count <= '0;
      frame_ok      <= 1'b0;
      kind          <= KIND_NONE;
      written       <= '0;
    end else if (cmd.take) begin
      latched_start <= start_next;
      latched_count <= count_next;
      frame_ok      <= ok_next;
      kind          <= kind_next;
      if (we) begin
        written[widx[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      dest <= req.frame_source;
      rcmd <= rcmd_next;
      rlen <= rlen_next;
    end
  end

  // Byte index of the reply: start, count, then one register per step.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      k <= '0;
    end else if (cmd.load) begin
      k <= k + 6'd1;
    end
  end

  assign raddr = {1'b0, latched_start} + {3'b000, k - 6'd2};

  always_ff @(posedge clk) begin
    if (cmd.take && we) begin
      mem[widx[AW-1:0]] <= req.byte_value;
    end
    if (cmd.fetch) begin
      rdata <= mem[raddr[AW-1:0]];
      rd_ok <= ({1'b0, raddr} < REG_LIMIT) && written[raddr[AW-1:0]];
    end
  end

  always_comb begin
    if (kind != KIND_READ) begin
      send_byte = '0;
    end else if (k == 6'd0) begin
      send_byte = latched_start;
    end else if (k == 6'd1) begin
      send_byte = latched_count;
    end else if (rd_ok) begin
      send_byte = rdata;
    end else begin
      send_byte = '0;
    end
  end

  assign stat.kind      = kind;
  assign stat.out_free  = !rsp_valid || rsp_ready;
  assign stat.item_last = (kind == KIND_SINGLE) || ((k + 6'd1) == rlen);
  assign stat.next_mem  = (kind == KIND_READ) && (k != 6'd0);

  // Output register: holds one reply item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.reply_dest <= dest;
      rsp.reply_cmd  <= rcmd;
      rsp.reply_len  <= rlen;
      rsp.reply_byte <= send_byte;
      rsp.has_byte   <= (kind == KIND_READ);
      rsp.reply_last <= stat.item_last;
    end
  end

endmodule

FILE: hw/rtl/frame_register_slave.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   frs_req_t: one received payload byte and header
// rsp       out        rsp_valid/rsp_ready   frs_rsp_t: one reply item
//
// A request item that ends no reply is accepted in IDLE and decided in DECIDE.
// A PING or acknowledged WRITE passes IDLE, DECIDE and SEND up to the loaded reply.
// A READ reply streams count + 2 items; register bytes pass FETCH, for the store
// read port, and then SEND, which loads the item into the output register.
// Reset clears the register store through one written bit per entry, so the
// block is ready in the first cycle after reset. A stalled reply holds the
// sequencer; the output register lets the next request enter once the last
// reply item of a frame is loaded.

module frame_register_slave #(
  parameter int REG_COUNT = frs_pkg::REG_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  frs_pkg::frs_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output frs_pkg::frs_rsp_t rsp
);
  import frs_pkg::*;

  // The controller sequences each transaction; the datapath holds the header
  // state, the register store and the output register.
  frs_cmd_t  cmd;
  frs_stat_t stat;

  frs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  frs_datapath #(
    .REG_COUNT (REG_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: hw/rtl/frs_checker.sv
`timescale 1ns / 1ps

module frs_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input frs_pkg::frs_rsp_t rsp
);
  import frs_pkg::*;

  // Requests are taken one at a time: the cycle after a request transaction
  // the block is busy deciding and does not accept another.
  a_req_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  // A stalled reply item stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("reply item changed while stalled");

  // An item without payload is a complete empty PONG or ACK frame.
  a_empty_reply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.has_byte |->
      rsp.reply_last && rsp.reply_len == 6'd0 &&
      (rsp.reply_cmd == OP_PONG || rsp.reply_cmd == OP_ACK))
    else $error("malformed empty reply");

  // Payload items belong only to READ replies of at least start and count.
  a_read_reply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.has_byte |->
      rsp.reply_cmd == OP_READ && rsp.reply_len >= 6'd2)
    else $error("payload byte outside a read reply");

  // Items of one reply frame go to one destination without interleaving.
  a_frame_dest: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp.reply_last |=>
      !rsp_valid || (rsp.reply_dest == $past(rsp.reply_dest) &&
                     rsp.reply_cmd == $past(rsp.reply_cmd)))
    else $error("reply frame interrupted");

endmodule

bind frame_register_slave frs_checker u_frs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
